/* hw/rtl/skf_pkg.sv */
`timescale 1ns / 1ps

package skf_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEASURE_NOISE = 1'b1
  } cfg_idx_t;

  localparam int unsigned NOISE_W = 16;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CHAN_W = 2;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 16'd1180;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 16'd3552;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic mul;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/skf_ctrl.sv */
`timescale 1ns / 1ps

module skf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  skf_pkg::status_t status,
  output skf_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  skf_pkg::state_t state;
  skf_pkg::state_t state_next;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      skf_pkg::ST_IDLE: begin
        // No transfer is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = skf_pkg::ST_PREP;
        end
      end
      skf_pkg::ST_PREP: begin
        // A channel beyond the filter bank goes straight to the result.
        if (status.in_range) begin
          cmd.prep   = 1'b1;
          step_next  = '0;
          state_next = skf_pkg::ST_DIV;
        end else begin
          state_next = skf_pkg::ST_COMMIT;
        end
      end
      skf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == CNT_W'(FRAC_BITS)) begin
          state_next = skf_pkg::ST_MUL;
        end
      end
      skf_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = skf_pkg::ST_COMMIT;
      end
      skf_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = skf_pkg::ST_IDLE;
        end
      end
      default: state_next = skf_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/skf_datapath.sv */
`timescale 1ns / 1ps

module skf_datapath #(
  parameter int CHANNELS  = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  skf_pkg::cfg_idx_t             cfg_addr,
  input  logic [skf_pkg::NOISE_W-1:0]   cfg_wdata,
  input  logic [skf_pkg::CHAN_W-1:0]    in_channel,
  input  logic [skf_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skf_pkg::CHAN_W-1:0]    out_channel,
  output logic [skf_pkg::SAMPLE_W-1:0]  out_filtered,
  input  skf_pkg::cmd_t                 cmd,
  output skf_pkg::status_t              status
);

  localparam int F     = FRAC_BITS;
  localparam int COV_W = 4 + F;
  localparam int EST_W = skf_pkg::SAMPLE_W + F;
  localparam int DEN_W = ((COV_W > skf_pkg::NOISE_W) ? COV_W : skf_pkg::NOISE_W) + 1;
  localparam int G_W   = F + 1;
  localparam int PE_W  = G_W + EST_W + 2;
  localparam int PC_W  = G_W + COV_W;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHW_W = IDX_W + skf_pkg::CHAN_W;

  localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
  localparam logic [G_W-1:0]   ONE_FX  = {1'b1, {F{1'b0}}};

  logic [skf_pkg::NOISE_W-1:0] process_noise;
  logic [skf_pkg::NOISE_W-1:0] measure_noise;

  logic [EST_W-1:0] est_mem [CHANNELS];
  logic [COV_W-1:0] cov_mem [CHANNELS];

  logic [skf_pkg::CHAN_W-1:0]   chan;
  logic [skf_pkg::SAMPLE_W-1:0] smp;
  logic [COV_W-1:0]             pmid;
  logic [DEN_W-1:0]             den;
  logic                         den_zero;
  logic [DEN_W:0]               rem;
  logic [G_W-1:0]               quo;
  logic [EST_W-1:0]             est_cur;
  logic signed [PE_W-1:0]       prod_e;
  logic [PC_W-1:0]              prod_c;

  logic [CHW_W-1:0]       chan_wide;
  logic [IDX_W-1:0]       idx;
  logic                   in_range;
  logic [DEN_W-1:0]       pmid_sum;
  logic [COV_W-1:0]       pmid_sat;
  logic [DEN_W:0]         rem_sub;
  logic                   quo_bit;
  logic [G_W-1:0]         gain;
  logic signed [EST_W:0]  diff;
  logic signed [PE_W-1:0] upd;
  logic signed [PE_W:0]   est_sum;
  logic [EST_W-1:0]       est_new;
  logic [COV_W-1:0]       cov_new;

  assign chan_wide = CHW_W'(chan);
  assign idx       = chan_wide[IDX_W-1:0];
  assign in_range  = (chan_wide < CHW_W'(CHANNELS));

  assign status.in_range = in_range;
  assign status.out_free = !out_valid || out_ready;

  // Predicted covariance, saturated to the covariance width.
  assign pmid_sum = DEN_W'(cov_mem[idx]) + DEN_W'(process_noise);
  assign pmid_sat = (pmid_sum > DEN_W'(COV_MAX)) ? COV_MAX : pmid_sum[COV_W-1:0];

  // One quotient bit per step of the restoring divider.
  assign quo_bit = (rem >= {1'b0, den});
  assign rem_sub = quo_bit ? (rem - {1'b0, den}) : rem;

  assign gain = den_zero ? ONE_FX : quo;
  assign diff = $signed({1'b0, smp, {F{1'b0}}}) - $signed({1'b0, est_cur});

  assign upd     = prod_e >>> F;
  assign est_sum = $signed({{(PE_W - EST_W){1'b0}}, est_cur}) + (PE_W + 1)'(upd);
  assign cov_new = prod_c[F +: COV_W];

  always_comb begin
    if (est_sum < 0) begin
      est_new = '0;
    end else if (est_sum > $signed({{(PE_W + 1 - EST_W){1'b0}}, EST_MAX})) begin
      est_new = EST_MAX;
    end else begin
      est_new = est_sum[EST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= skf_pkg::PROCESS_NOISE_RST;
      measure_noise <= skf_pkg::MEASURE_NOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        skf_pkg::REG_PROCESS_NOISE: process_noise <= cfg_wdata;
        skf_pkg::REG_MEASURE_NOISE: measure_noise <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        est_mem[i] <= '0;
        cov_mem[i] <= '0;
      end
    end else if (cmd.commit && in_range) begin
      est_mem[idx] <= est_new;
      cov_mem[idx] <= cov_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chan <= in_channel;
      smp  <= in_sample;
    end
    if (cmd.prep) begin
      pmid     <= pmid_sat;
      den      <= DEN_W'(pmid_sat) + DEN_W'(measure_noise);
      den_zero <= (pmid_sat == '0) && (measure_noise == '0);
      rem      <= (DEN_W + 1)'(pmid_sat);
      quo      <= '0;
      est_cur  <= est_mem[idx];
    end
    if (cmd.div_step) begin
      rem <= {rem_sub[DEN_W-1:0], 1'b0};
      quo <= {quo[G_W-2:0], quo_bit};
    end
    if (cmd.mul) begin
      prod_e <= $signed({1'b0, gain}) * diff;
      prod_c <= (ONE_FX - gain) * pmid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_channel  <= chan;
      out_filtered <= in_range ? est_new[F +: skf_pkg::SAMPLE_W] : '0;
    end
  end

endmodule

/* hw/rtl/scalar_kalman_sample_filter_top.sv */
`timescale 1ns / 1ps

// One-dimensional Kalman filter bank for 12-bit converter samples, one filter
// per channel with estimate and covariance cleared at reset. Each sample goes
// through capture, prediction, the restoring gain divider that produces one
// quotient bit per cycle, the gain multiply and the commit; a sample for a
// channel beyond CHANNELS goes straight to the commit and returns zero. A new
// sample is taken once the previous one has been written to the
// output register, so a result may wait downstream while the next is computed.
// Write process_noise and measure_noise only while the filter is idle.
module scalar_kalman_sample_filter_top #(
  parameter int CHANNELS  = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_addr,
  input  logic [15:0]             cfg_wdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,   // [11:0] sample, [15:12] zero
  input  logic [1:0]              s_axis_tuser,   // [1:0] channel
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [11:0] filtered, [15:12] zero
  output logic [1:0]              m_axis_tuser    // [1:0] channel_out
);

  skf_pkg::cmd_t    cmd;
  skf_pkg::status_t status;
  logic [skf_pkg::SAMPLE_W-1:0] filtered;

  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  skf_datapath #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (skf_pkg::cfg_idx_t'(cfg_addr)),
    .cfg_wdata    (cfg_wdata),
    .in_channel   (s_axis_tuser),
    .in_sample    (s_axis_tdata[skf_pkg::SAMPLE_W-1:0]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_channel  (m_axis_tuser),
    .out_filtered (filtered),
    .cmd          (cmd),
    .status       (status)
  );

  assign m_axis_tdata = {4'b0000, filtered};

endmodule

/* dv/tb_scalar_kalman_sample_filter_top.sv */
`timescale 1ns / 1ps

module tb_scalar_kalman_sample_filter_top;

  localparam int NUM_CHAN = 4;
  localparam int FRAC = 16;
  localparam longint ONE_Q16 = 64'd1 << FRAC;
  localparam longint COV_SAT = (64'd1 << (4 + FRAC)) - 1;
  localparam longint EST_SAT = (64'd1 << (12 + FRAC)) - 1;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 8;

  typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    skf_pkg::cfg_idx_t  idx;
    logic [1:0]         ch;
    logic [15:0]        val;
    logic               typed;
    logic [11:0]        want;
  } plan_row_t;

  typedef struct packed {
    logic [1:0]  ch;
    logic [11:0] filt;
  } kalman_out_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  skf_pkg::cfg_idx_t cfg_addr = skf_pkg::REG_PROCESS_NOISE;
  logic [15:0]       cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // [11:0] sample, [15:12] zero
  logic [1:0]        s_axis_tuser = '0;   // [1:0] channel
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [11:0] filtered, [15:12] zero
  logic [1:0]        m_axis_tuser;        // [1:0] channel_out

  // Mirror of the filter state and noise settings.
  logic [27:0] est_q16 [NUM_CHAN];
  logic [19:0] cov_q16 [NUM_CHAN];
  logic [15:0] proc_noise;
  logic [15:0] meas_noise;

  kalman_out_t filtered_q [$];
  int          n_errors = 0;
  int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int          level [NUM_CHAN];

  // Directed plan: gain is exactly one whenever R is zero, so those rows
  // carry the sample itself as the expected value.
  plan_row_t plan [24] = '{
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd4095,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd1, 16'd0,     1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd4095,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd2, 16'd2048,  1'b0, 12'd0},
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd0,     1'b0, 12'd0},
    '{ROW_WRITE,  skf_pkg::REG_MEASURE_NOISE, 2'd0, 16'd0,     1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd3, 16'd4095,  1'b1, 12'd4095},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd3, 16'd0,     1'b1, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd2, 16'hAAA,   1'b1, 12'hAAA},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd1, 16'h555,   1'b1, 12'h555},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd0,     1'b1, 12'd0},
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'hFFFF,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd4095,  1'b1, 12'd4095},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd1, 16'd0,     1'b1, 12'd0},
    '{ROW_WRITE,  skf_pkg::REG_MEASURE_NOISE, 2'd0, 16'hFFFF,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd2, 16'd4095,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd2, 16'd4095,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd3, 16'hFFF,   1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd0,     1'b0, 12'd0},
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, 2'd0, 16'd0,     1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd1, 16'd4095,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd1, 16'd4095,  1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd3, 16'd1,     1'b0, 12'd0},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 2'd2, 16'h800,   1'b0, 12'd0}
  };

  scalar_kalman_sample_filter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_scalar_kalman_sample_filter_top: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // One filter step on the mirrored state; returns the integer estimate.
  function automatic logic [11:0] kalman_update(input logic [1:0] ch, input logic [11:0] smp);
    longint pmid, den, gain, diff, upd, nxt;
    if (ch >= NUM_CHAN) return 12'd0;
    pmid = longint'(cov_q16[ch]) + longint'(proc_noise);
    if (pmid > COV_SAT) pmid = COV_SAT;
    den = pmid + longint'(meas_noise);
    if (den == 0) gain = ONE_Q16;
    else gain = (pmid << FRAC) / den;
    if (gain > ONE_Q16) gain = ONE_Q16;
    diff = (longint'(smp) << FRAC) - longint'(est_q16[ch]);
    // Arithmetic shift floors toward minus infinity for negative steps.
    upd = (gain * diff) >>> FRAC;
    nxt = longint'(est_q16[ch]) + upd;
    if (nxt < 0) nxt = 0;
    if (nxt > EST_SAT) nxt = EST_SAT;
    est_q16[ch] = nxt[27:0];
    cov_q16[ch] = 20'((((ONE_Q16 - gain) * pmid) >>> FRAC) & COV_SAT);
    return est_q16[ch][27:16];
  endfunction

  // Registers change only with nothing in flight.
  task automatic write_reg(input skf_pkg::cfg_idx_t idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == skf_pkg::REG_PROCESS_NOISE) proc_noise = val;
    else meas_noise = val;
  endtask

  task automatic push_sample(input logic [1:0] ch, input logic [11:0] smp,
                             input logic typed, input logic [11:0] want);
    int gap;
    int pct;
    kalman_out_t res;
    gap = 0;
    pct = (idle_mode == 1) ? 70 : (idle_mode == 3) ? 15 : 0;
    while ($urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= {4'b0, smp};
    do @(posedge clk); while (!s_axis_tready);
    res.ch   = ch;
    res.filt = kalman_update(ch, smp);
    if (typed) res.filt = want;
    filtered_q.push_back(res);
  endtask

  function automatic logic [11:0] next_sample(input int ch);
    int v;
    if ($urandom_range(99) < 25) return 12'($urandom_range(4095));
    if ($urandom_range(99) < 5) level[ch] = $urandom_range(4095);
    v = level[ch] + $urandom_range(64) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    level[ch] = v;
    return 12'(v);
  endfunction

  // Receiver backpressure.
  always @(posedge clk) begin
    if (idle_mode == 2) m_axis_tready <= ($urandom_range(99) >= 70);
    else if (idle_mode == 3) m_axis_tready <= ($urandom_range(99) >= 15);
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin : result_check
    kalman_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch %0d data %0d",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tuser != want.ch)
          report_mismatch($sformatf("channel_out %0d, expected %0d", m_axis_tuser, want.ch));
        if (m_axis_tdata != {4'b0, want.filt})
          report_mismatch($sformatf("ch %0d filtered %0d, expected %0d",
                                    want.ch, m_axis_tdata, want.filt));
      end
    end
  end

  initial begin
    logic [1:0] ch;
    proc_noise = skf_pkg::PROCESS_NOISE_RST;
    meas_noise = skf_pkg::MEASURE_NOISE_RST;
    for (int i = 0; i < NUM_CHAN; i++) begin
      est_q16[i] = '0;
      cov_q16[i] = '0;
      level[i] = $urandom_range(4095);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else push_sample(plan[i].ch, plan[i].val[11:0], plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      unique case (ph)
        0: begin
          write_reg(skf_pkg::REG_PROCESS_NOISE, skf_pkg::PROCESS_NOISE_RST);
          write_reg(skf_pkg::REG_MEASURE_NOISE, skf_pkg::MEASURE_NOISE_RST);
        end
        2: begin
          write_reg(skf_pkg::REG_PROCESS_NOISE, 16'hFFFF);
          write_reg(skf_pkg::REG_MEASURE_NOISE, 16'hFFFF);
        end
        3: begin
          write_reg(skf_pkg::REG_PROCESS_NOISE, 16'd0);
          write_reg(skf_pkg::REG_MEASURE_NOISE, 16'($urandom_range(65535)));
        end
        4: begin
          write_reg(skf_pkg::REG_PROCESS_NOISE, 16'($urandom_range(65535)));
          write_reg(skf_pkg::REG_MEASURE_NOISE, 16'd0);
        end
        5: begin
          write_reg(skf_pkg::REG_PROCESS_NOISE, 16'($urandom_range(63)));
          write_reg(skf_pkg::REG_MEASURE_NOISE, 16'($urandom_range(65535)));
        end
        default: begin
          write_reg(skf_pkg::REG_PROCESS_NOISE, 16'($urandom_range(65535)));
          write_reg(skf_pkg::REG_MEASURE_NOISE, 16'($urandom_range(65535)));
        end
      endcase
      idle_mode = ph % 4;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = 2'($urandom_range(NUM_CHAN - 1));
        push_sample(ch, next_sample(ch), 1'b0, 12'd0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_scalar_kalman_sample_filter_top: done, clean");
    end else begin
      $display("tb_scalar_kalman_sample_filter_top: done, errors");
    end
    $finish;
  end

endmodule
